FILE: hw/rtl/ecr_pkg.sv
// ----------------------------------------------------------------------------
// ecr_pkg: shared definitions for the event coordinate rotator
// Register indexes of the configuration port and the decoded mode bundle.
// ----------------------------------------------------------------------------
package ecr_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Q         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Q         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y        = 3'd5;

  // Bit positions inside the mode flags register.
  localparam int MODE_BIT_SWAP  = 0;
  localparam int MODE_BIT_ROT90 = 1;
  localparam int MODE_BIT_INV_X = 2;
  localparam int MODE_BIT_INV_Y = 3;

  // Decoded transform enables handed from the register file to the datapath.
  typedef struct packed {
    logic rotate_en;
    logic inv_y;
    logic inv_x;
    logic rot90;
    logic swap;
  } ecr_mode_t;

endpackage

FILE: hw/rtl/ecr_cfg_regs.sv
// ----------------------------------------------------------------------------
// ecr_cfg_regs: configuration register file
// Holds the transform enables, the Q-format cosine and sine, and the sensor
// sizes, which are stored already limited to the range the datapath expects.
// ----------------------------------------------------------------------------
module ecr_cfg_regs #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14,
  localparam int TRIG_W = FRAC_BITS + 2,
  localparam int SIZE_W = COORD_BITS + 1,
  localparam int CFG_DW = (TRIG_W > SIZE_W) ? TRIG_W : SIZE_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]              cfg_wdata,
  output ecr_pkg::ecr_mode_t             mode,
  output logic signed [TRIG_W-1:0]       cos_q,
  output logic signed [TRIG_W-1:0]       sin_q,
  output logic [SIZE_W-1:0]              size_x,
  output logic [SIZE_W-1:0]              size_y
);

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(1) << COORD_BITS;
  localparam logic [TRIG_W-1:0] ONE_Q    = TRIG_W'(1) << FRAC_BITS;

  ecr_pkg::ecr_mode_t       mode_r;
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;
  logic [SIZE_W-1:0]        size_x_r;
  logic [SIZE_W-1:0]        size_y_r;
  logic [SIZE_W-1:0]        size_wr;
  logic [SIZE_W-1:0]        size_eff;

  // A size of zero acts as one, and anything above the coordinate range acts
  // as the full range, so the limit is applied once when the size is written.
  assign size_wr  = cfg_wdata[SIZE_W-1:0];
  assign size_eff = (size_wr == '0) ? SIZE_W'(1) :
                    (size_wr > MAX_SIZE) ? MAX_SIZE : size_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      cos_r    <= $signed(ONE_Q);
      sin_r    <= '0;
      size_x_r <= MAX_SIZE;
      size_y_r <= MAX_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        ecr_pkg::REG_MODE_FLAGS: begin
          mode_r.swap  <= cfg_wdata[ecr_pkg::MODE_BIT_SWAP];
          mode_r.rot90 <= cfg_wdata[ecr_pkg::MODE_BIT_ROT90];
          mode_r.inv_x <= cfg_wdata[ecr_pkg::MODE_BIT_INV_X];
          mode_r.inv_y <= cfg_wdata[ecr_pkg::MODE_BIT_INV_Y];
        end
        ecr_pkg::REG_ROTATE_ENABLE: mode_r.rotate_en <= cfg_wdata[0];
        ecr_pkg::REG_COS_Q:         cos_r    <= $signed(cfg_wdata[TRIG_W-1:0]);
        ecr_pkg::REG_SIN_Q:         sin_r    <= $signed(cfg_wdata[TRIG_W-1:0]);
        ecr_pkg::REG_SIZE_X:        size_x_r <= size_eff;
        ecr_pkg::REG_SIZE_Y:        size_y_r <= size_eff;
        default: ;
      endcase
    end
  end

  assign mode   = mode_r;
  assign cos_q  = cos_r;
  assign sin_q  = sin_r;
  assign size_x = size_x_r;
  assign size_y = size_y_r;

endmodule

FILE: hw/rtl/ecr_remap.sv
// ----------------------------------------------------------------------------
// ecr_remap: coordinate remapping datapath
// Combinational swap, quarter turn, mirror and arbitrary-angle rotation of one
// event, with clamping of every remapped coordinate to the sensor area.
// ----------------------------------------------------------------------------
module ecr_remap #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14,
  localparam int TRIG_W = FRAC_BITS + 2,
  localparam int SIZE_W = COORD_BITS + 1
) (
  input  ecr_pkg::ecr_mode_t         mode,
  input  logic signed [TRIG_W-1:0]   cos_q,
  input  logic signed [TRIG_W-1:0]   sin_q,
  input  logic [SIZE_W-1:0]          size_x,
  input  logic [SIZE_W-1:0]          size_y,
  input  logic [COORD_BITS-1:0]      x_in,
  input  logic [COORD_BITS-1:0]      y_in,
  output logic [COORD_BITS-1:0]      x_out,
  output logic [COORD_BITS-1:0]      y_out
);

  localparam int DW   = COORD_BITS + 1;     // offset from the center
  localparam int PW   = TRIG_W + DW;        // one product
  localparam int SUMW = PW + 1;             // sum of two products
  localparam int LW   = SUMW + 1;           // working width after rounding
  localparam logic [SUMW:0] HALF = (SUMW + 1)'(1) << (FRAC_BITS - 1);

  // Limits a value to 0 .. size-1.
  function automatic logic [COORD_BITS-1:0] clamp_to(input logic signed [LW-1:0] v,
                                                     input logic [SIZE_W-1:0] size);
    logic signed [LW-1:0] top;
    top = $signed(LW'(size)) - $signed(LW'(1));
    if (v < 0) begin
      clamp_to = '0;
    end else if (v > top) begin
      clamp_to = top[COORD_BITS-1:0];
    end else begin
      clamp_to = v[COORD_BITS-1:0];
    end
  endfunction

  // Drops the fraction, rounding half away from zero.
  function automatic logic signed [LW-1:0] round_q(input logic signed [SUMW-1:0] v);
    logic            neg;
    logic [SUMW-1:0] mag;
    logic [SUMW:0]   biased;
    logic [LW-1:0]   r;
    neg    = v[SUMW-1];
    mag    = neg ? unsigned'(-v) : unsigned'(v);
    biased = {1'b0, mag} + HALF;
    r      = LW'(biased >> FRAC_BITS);
    round_q = neg ? -$signed(r) : $signed(r);
  endfunction

  logic signed [LW-1:0]   xs;
  logic signed [LW-1:0]   ys;
  logic signed [LW-1:0]   inv_x_v;
  logic signed [LW-1:0]   inv_y_v;
  logic [COORD_BITS-1:0]  cx;
  logic [COORD_BITS-1:0]  cy;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic signed [PW-1:0]   p_cos_dx;
  logic signed [PW-1:0]   p_sin_dy;
  logic signed [PW-1:0]   p_sin_dx;
  logic signed [PW-1:0]   p_cos_dy;
  logic signed [SUMW-1:0] sum_x;
  logic signed [SUMW-1:0] sum_y;
  logic signed [LW-1:0]   rot_x;
  logic signed [LW-1:0]   rot_y;

  assign xs      = $signed(LW'(x_in));
  assign ys      = $signed(LW'(y_in));
  assign inv_x_v = $signed(LW'(size_x)) - $signed(LW'(1)) - xs;
  assign inv_y_v = $signed(LW'(size_y)) - $signed(LW'(1)) - ys;

  // Rotation about the integer center of the sensor.
  assign cx = size_x[COORD_BITS:1];
  assign cy = size_y[COORD_BITS:1];
  assign dx = $signed({1'b0, x_in}) - $signed({1'b0, cx});
  assign dy = $signed({1'b0, y_in}) - $signed({1'b0, cy});

  assign p_cos_dx = cos_q * dx;
  assign p_sin_dy = sin_q * dy;
  assign p_sin_dx = sin_q * dx;
  assign p_cos_dy = cos_q * dy;

  assign sum_x = SUMW'(p_cos_dx) - SUMW'(p_sin_dy);
  assign sum_y = SUMW'(p_sin_dx) + SUMW'(p_cos_dy);

  assign rot_x = round_q(sum_x) + $signed(LW'(cx));
  assign rot_y = round_q(sum_y) + $signed(LW'(cy));

  // Later transforms take priority over earlier ones; all read the original
  // coordinates.
  always_comb begin
    x_out = x_in;
    y_out = y_in;
    if (mode.swap) begin
      x_out = clamp_to(ys, size_x);
      y_out = clamp_to(xs, size_y);
    end
    if (mode.rot90) begin
      x_out = clamp_to(inv_y_v, size_x);
      y_out = clamp_to(xs, size_y);
    end
    if (mode.inv_x) begin
      x_out = clamp_to(inv_x_v, size_x);
    end
    if (mode.inv_y) begin
      y_out = clamp_to(inv_y_v, size_y);
    end
    if (mode.rotate_en) begin
      x_out = clamp_to(rot_x, size_x);
      y_out = clamp_to(rot_y, size_y);
    end
  end

endmodule

FILE: hw/rtl/event_coordinate_rotator_unit.sv
// ----------------------------------------------------------------------------
// event_coordinate_rotator_unit: remaps the coordinates of sensor events
// Swaps, turns, mirrors or rotates each event about the sensor center.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the in_ channel (in_valid / in_stall) and leave on the out_
// channel (out_valid / out_stall); a transfer happens at a rising clock edge
// where valid is high and stall is low. Each event gives exactly one result,
// in order, with its polarity unchanged.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one register
// per enabled clock edge. Write it only while no event is in flight.
// An event is captured in the input register, remapped by the datapath
// between that register and the result register, and shown on the out_ ports
// from the result register. Throughput is one event per cycle while the
// receiver does not stall; one pass through the rotation multipliers sets it.
// When the receiver stalls, the result register holds its event and the input
// register can still take one more; in_stall rises only when both are full,
// so a stall costs no bubble once released.
// Reset (rst_n low, synchronous) empties both registers and restores the
// register defaults: no transform, unit cosine, zero sine, full-size sensor.
// ----------------------------------------------------------------------------
module event_coordinate_rotator_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14,
  localparam int TRIG_W = FRAC_BITS + 2,
  localparam int SIZE_W = COORD_BITS + 1,
  localparam int CFG_DW = (TRIG_W > SIZE_W) ? TRIG_W : SIZE_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port.
  input  logic                          cfg_we,
  input  logic [ecr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]             cfg_wdata,
  // Event input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [COORD_BITS-1:0]         in_x_in,
  input  logic [COORD_BITS-1:0]         in_y_in,
  input  logic                          in_polarity_in,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_BITS-1:0]         out_x_out,
  output logic [COORD_BITS-1:0]         out_y_out,
  output logic                          out_polarity_out
);

  ecr_pkg::ecr_mode_t       mode;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;
  logic [SIZE_W-1:0]        size_x;
  logic [SIZE_W-1:0]        size_y;

  // Input register.
  logic                  s1_valid_r;
  logic [COORD_BITS-1:0] s1_x_r;
  logic [COORD_BITS-1:0] s1_y_r;
  logic                  s1_pol_r;

  // Result register.
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic                  out_pol_r;

  logic                  out_ready;
  logic                  s1_move;
  logic                  in_take;
  logic [COORD_BITS-1:0] x_nxt;
  logic [COORD_BITS-1:0] y_nxt;

  ecr_cfg_regs #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mode      (mode),
    .cos_q     (cos_q),
    .sin_q     (sin_q),
    .size_x    (size_x),
    .size_y    (size_y)
  );

  ecr_remap #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_remap (
    .mode   (mode),
    .cos_q  (cos_q),
    .sin_q  (sin_q),
    .size_x (size_x),
    .size_y (size_y),
    .x_in   (s1_x_r),
    .y_in   (s1_y_r),
    .x_out  (x_nxt),
    .y_out  (y_nxt)
  );

  // The result register can load when it is empty or its event leaves now.
  // The input register moves forward whenever the result register can load,
  // and so it can refill in the same cycle.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take || s1_move) begin
        s1_valid_r <= in_take;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers carry no reset; they load only on a transfer.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r   <= in_x_in;
      s1_y_r   <= in_y_in;
      s1_pol_r <= in_polarity_in;
    end
    if (s1_move) begin
      out_x_r   <= x_nxt;
      out_y_r   <= y_nxt;
      out_pol_r <= s1_pol_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x_out        = out_x_r;
  assign out_y_out        = out_y_r;
  assign out_polarity_out = out_pol_r;

  // Reset leaves both pipeline registers empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  // The input side is held off only while an event waits in the input register.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // An event that moves forward appears as a result on the next cycle.
  a_move_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("event lost between input and result registers");

endmodule

FILE: tb/sv/event_coordinate_rotator_unit_test.sv
// ----------------------------------------------------------------------------
// event_coordinate_rotator_unit_test: self-checking bench for the rotator
// Walks the block through a series of register settings and streams events
// under random burst gaps and receiver back-pressure. A local predictor
// computes each remapped event, and a monitor compares every result.
// ----------------------------------------------------------------------------
module event_coordinate_rotator_unit_test;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 14;
  localparam int CFG_DW     = 16;
  localparam int MAX_SIZE   = 1 << COORD_BITS;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 300000;

  // Mode flag masks built from the bit positions of the package.
  localparam logic [3:0] MODE_NONE  = 4'd0;
  localparam logic [3:0] MODE_SWAP  = 4'(1 << ecr_pkg::MODE_BIT_SWAP);
  localparam logic [3:0] MODE_ROT90 = 4'(1 << ecr_pkg::MODE_BIT_ROT90);
  localparam logic [3:0] MODE_INV_X = 4'(1 << ecr_pkg::MODE_BIT_INV_X);
  localparam logic [3:0] MODE_INV_Y = 4'(1 << ecr_pkg::MODE_BIT_INV_Y);

  // One sensor event, used both for pending stimulus and for predictions.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  pol;
  } sensor_evt_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [ecr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]             cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [COORD_BITS-1:0]         in_x_in = '0;
  logic [COORD_BITS-1:0]         in_y_in = '0;
  logic                          in_polarity_in = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [COORD_BITS-1:0]         out_x_out;
  logic [COORD_BITS-1:0]         out_y_out;
  logic                          out_polarity_out;

  // Shadow copy of the register file, kept in step with every write.
  logic [3:0]        mode_sh;
  logic              rot_en_sh;
  logic signed [15:0] cos_sh;
  logic signed [15:0] sin_sh;
  logic [12:0]       size_x_sh;
  logic [12:0]       size_y_sh;

  sensor_evt_t event_backlog[$];  // events waiting for the driver
  sensor_evt_t remapped_q[$];     // predicted results, oldest first
  int mismatches = 0;
  int cycles = 0;

  event_coordinate_rotator_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_in         (in_x_in),
    .in_y_in         (in_y_in),
    .in_polarity_in  (in_polarity_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_out       (out_x_out),
    .out_y_out       (out_y_out),
    .out_polarity_out(out_polarity_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A size of zero behaves as one pixel, and anything above the coordinate
  // range behaves as the full range.
  function automatic longint active_size(logic [12:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIZE) return MAX_SIZE;
    return longint'(s);
  endfunction

  function automatic longint clamp_to_size(longint v, longint sz);
    if (v < 0) return 0;
    if (v > sz - 1) return sz - 1;
    return v;
  endfunction

  // Sum of products with Q2.14 factors to integer, rounding half away from zero.
  function automatic longint round_half_away(longint v);
    longint half;
    half = longint'(1) << (FRAC_BITS - 1);
    if (v < 0) return -((-v + half) >> FRAC_BITS);
    return (v + half) >> FRAC_BITS;
  endfunction

  // Every transform looks at the original coordinates; a later enabled
  // transform simply overwrites what an earlier one produced.
  function automatic sensor_evt_t remap_event(sensor_evt_t ev);
    longint sx, sy, xi, yi, ox, oy, cx, cy, dx, dy, rx, ry;
    sensor_evt_t res;
    sx = active_size(size_x_sh);
    sy = active_size(size_y_sh);
    xi = longint'(ev.x);
    yi = longint'(ev.y);
    ox = xi;
    oy = yi;
    if (mode_sh[ecr_pkg::MODE_BIT_SWAP]) begin
      ox = clamp_to_size(yi, sx);
      oy = clamp_to_size(xi, sy);
    end
    if (mode_sh[ecr_pkg::MODE_BIT_ROT90]) begin
      ox = clamp_to_size(sy - 1 - yi, sx);
      oy = clamp_to_size(xi, sy);
    end
    if (mode_sh[ecr_pkg::MODE_BIT_INV_X]) begin
      ox = clamp_to_size(sx - 1 - xi, sx);
    end
    if (mode_sh[ecr_pkg::MODE_BIT_INV_Y]) begin
      oy = clamp_to_size(sy - 1 - yi, sy);
    end
    if (rot_en_sh) begin
      cx = sx / 2;
      cy = sy / 2;
      dx = xi - cx;
      dy = yi - cy;
      rx = round_half_away(longint'(cos_sh) * dx - longint'(sin_sh) * dy);
      ry = round_half_away(longint'(sin_sh) * dx + longint'(cos_sh) * dy);
      ox = clamp_to_size(rx + cx, sx);
      oy = clamp_to_size(ry + cy, sy);
    end
    res.x   = ox[COORD_BITS-1:0];
    res.y   = oy[COORD_BITS-1:0];
    res.pol = ev.pol;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents pending events in bursts separated by random gaps.
  // A presented event is held unchanged for as long as the block stalls it.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    sensor_evt_t nxt;
    sensor_evt_t shown;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // The event on the ports at this edge completes its transfer now, so
      // its prediction joins the queue with the configuration in force.
      if (in_valid && !in_stall) begin
        shown.x   = in_x_in;
        shown.y   = in_y_in;
        shown.pol = in_polarity_in;
        remapped_q.push_back(remap_event(shown));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (event_backlog.size() != 0) begin
          nxt = event_backlog.pop_front();
          in_valid       <= 1'b1;
          in_x_in        <= nxt.x;
          in_y_in        <= nxt.y;
          in_polarity_in <= nxt.pol;
          if (burst_left <= 1) begin
            // A zero gap now and then gives long stretches with no idling.
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: alternates free-running stretches with stall runs of random
  // length, including single-cycle stalls and long holds.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int free_left = 0;

  always @(posedge clk) begin
    logic stall_now;
    stall_now = 1'b0;
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (free_left > 0) begin
        free_left--;
      end else begin
        free_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                : $urandom_range(0, 3);
      end
    end
    out_stall <= stall_now;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    sensor_evt_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (remapped_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d pol=%0d",
                                  out_x_out, out_y_out, out_polarity_out));
      end else begin
        want = remapped_q.pop_front();
        if (out_x_out !== want.x)
          report_mismatch($sformatf("x_out %0d, predicted %0d", out_x_out, want.x));
        if (out_y_out !== want.y)
          report_mismatch($sformatf("y_out %0d, predicted %0d", out_y_out, want.y));
        if (out_polarity_out !== want.pol)
          report_mismatch($sformatf("polarity_out %0d, predicted %0d",
                                    out_polarity_out, want.pol));
      end
    end
  end

  // The run is cut off if it overstays a generous cycle budget.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("event_coordinate_rotator_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer tasks
  // ---------------------------------------------------------------------------

  // Sampled at the falling edge so the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (event_backlog.size() != 0 || remapped_q.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [ecr_pkg::CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      ecr_pkg::REG_MODE_FLAGS:    mode_sh   = data[3:0];
      ecr_pkg::REG_ROTATE_ENABLE: rot_en_sh = data[0];
      ecr_pkg::REG_COS_Q:         cos_sh    = data[15:0];
      ecr_pkg::REG_SIN_Q:         sin_sh    = data[15:0];
      ecr_pkg::REG_SIZE_X:        size_x_sh = data[12:0];
      ecr_pkg::REG_SIZE_Y:        size_y_sh = data[12:0];
      default: ;
    endcase
  endtask

  // Registers change only once the block is empty: both stages of the two-stage
  // pipeline have drained before the idle edges that precede the first write.
  task automatic apply_setting(logic [3:0] mode, logic rot, logic [15:0] cosv,
                               logic [15:0] sinv, logic [12:0] sx, logic [12:0] sy);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(ecr_pkg::REG_MODE_FLAGS, CFG_DW'(mode));
    write_reg(ecr_pkg::REG_ROTATE_ENABLE, CFG_DW'(rot));
    write_reg(ecr_pkg::REG_COS_Q, cosv);
    write_reg(ecr_pkg::REG_SIN_Q, sinv);
    write_reg(ecr_pkg::REG_SIZE_X, CFG_DW'(sx));
    write_reg(ecr_pkg::REG_SIZE_Y, CFG_DW'(sy));
    @(posedge clk);
    cfg_we <= 1'b0;
    // Events are queued at the following falling edge, after the last write has landed.
    @(negedge clk);
  endtask

  task automatic queue_event(int x, int y, int pol);
    sensor_evt_t ev;
    ev.x   = x[COORD_BITS-1:0];
    ev.y   = y[COORD_BITS-1:0];
    ev.pol = pol[0];
    event_backlog.push_back(ev);
  endtask

  // Coordinates are drawn from the full field, from inside the sensor, or
  // from just around its far edge, where the clamping decisions sit.
  function automatic int rand_coord(longint sz);
    longint v;
    case ($urandom_range(0, 2))
      0: v = $urandom_range(0, MAX_SIZE - 1);
      1: v = $urandom_range(0, int'(sz) - 1);
      default: v = sz - 2 + $urandom_range(0, 3);
    endcase
    if (v < 0) v = 0;
    if (v > MAX_SIZE - 1) v = MAX_SIZE - 1;
    return int'(v);
  endfunction

  function automatic logic [12:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'(MAX_SIZE);
      3: return 13'($urandom_range(MAX_SIZE + 1, 8191));
      4: return 13'($urandom_range(1, 64));
      default: return 13'($urandom_range(1, MAX_SIZE));
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    int phase;
    int count;
    longint sx;
    longint sy;

    // The shadow starts at the reset defaults of the register file.
    mode_sh   = MODE_NONE;
    rot_en_sh = 1'b0;
    cos_sh    = 16'sd16384;
    sin_sh    = 16'sd0;
    size_x_sh = 13'(MAX_SIZE);
    size_y_sh = 13'(MAX_SIZE);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: no transform, so coordinates pass through unclamped.
    queue_event(0, 0, 0);
    queue_event(4095, 4095, 1);
    queue_event(4095, 0, 1);
    queue_event(0, 4095, 0);

    // Axis swap on a small sensor, with coordinates past both edges.
    apply_setting(MODE_SWAP, 1'b0, 16'sd16384, 16'sd0, 13'd100, 13'd50);
    queue_event(10, 20, 1);
    queue_event(4095, 4095, 0);
    queue_event(99, 49, 1);

    // Quarter turn; a row past the sensor height gives a negative column.
    apply_setting(MODE_ROT90, 1'b0, 16'sd16384, 16'sd0, 13'd100, 13'd50);
    queue_event(0, 0, 0);
    queue_event(4000, 60, 1);
    queue_event(30, 49, 0);

    // Both mirrors with a zero width and an oversized height.
    apply_setting(MODE_INV_X | MODE_INV_Y, 1'b0, 16'sd16384, 16'sd0, 13'd0, 13'd8191);
    queue_event(0, 0, 1);
    queue_event(5, 4095, 0);
    queue_event(4095, 100, 1);

    // All mode flags together; the mirrors win over the swap and the turn.
    apply_setting(MODE_SWAP | MODE_ROT90 | MODE_INV_X | MODE_INV_Y, 1'b0,
                  16'sd16384, 16'sd0, 13'd640, 13'd480);
    queue_event(700, 500, 1);
    queue_event(0, 0, 0);

    // Ninety degree rotation; a corner swings past the far edge and must clamp.
    apply_setting(MODE_NONE, 1'b1, 16'sd0, 16'sd16384, 13'd64, 13'd64);
    queue_event(0, 0, 1);
    queue_event(63, 63, 0);
    queue_event(40, 10, 1);

    // Sine and cosine codes beyond one, taken as raw two's complement.
    apply_setting(MODE_SWAP, 1'b1, 16'h7FFF, 16'h8000, 13'(MAX_SIZE), 13'(MAX_SIZE));
    queue_event(2048, 2048, 0);
    queue_event(100, 4000, 1);
    queue_event(4095, 0, 0);

    // Half scale puts offsets of one exactly on the rounding midpoint.
    apply_setting(MODE_NONE, 1'b1, 16'sd8192, 16'sd0, 13'd64, 13'd64);
    queue_event(33, 31, 1);
    queue_event(31, 33, 0);

    // Random phases, each under a fresh random register setting.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_setting(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    rand_trig(), rand_trig(), rand_size(), rand_size());
      sx = active_size(size_x_sh);
      sy = active_size(size_y_sh);
      count = $urandom_range(40, 120);
      for (int i = 0; i < count; i++) begin
        // In one phase the sender holds off halfway until the block is empty.
        if (phase == 2 && i == count / 2) wait_drained();
        queue_event(rand_coord(sx), rand_coord(sy), $urandom_range(0, 1));
      end
      sent += count;
      phase++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (remapped_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", remapped_q.size()));
    if (mismatches == 0) begin
      $display("event_coordinate_rotator_unit verification clean");
    end else begin
      $display("event_coordinate_rotator_unit verification failed");
    end
    $finish;
  end

endmodule
